@@ rtl/waypoint_drive_controller_assert.svh @@
// Assertion macros for the waypoint drive controller.
// The clock is clk and the synchronous active-low reset is rst_n.
`ifndef WAYPOINT_DRIVE_CONTROLLER_ASSERT_SVH
`define WAYPOINT_DRIVE_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define WDC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("waypoint drive controller check failed");
// Next-cycle implication.
`define WDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("waypoint drive controller check failed");
`else
`define WDC_ASSERT_IMPL(lbl, ante, cons)
`define WDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/wdc_pkg.sv @@
`default_nettype none
package wdc_pkg;

  // Waypoint store geometry.
  localparam int PATH_DEPTH = 64;
  localparam int ADDR_W = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int LEN_W = $clog2(PATH_DEPTH + 1);

  // CORDIC datapath widths: vector components and angles in rad*2^20.
  localparam int CW = 45;
  localparam int ZW = 24;
  localparam int BW = ZW + 1;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W = 5;

  localparam logic signed [ZW-1:0] PI_Q20 = ZW'(3294199);
  localparam logic signed [BW-1:0] TWO_PI_Q20 = BW'(6588398);
  localparam logic signed [CW-1:0] NORM_LIMIT = CW'(64'sd1 <<< 40);

  localparam logic [15:0] SPEED_STEP = 16'd102;
  localparam logic signed [10:0] TURN_RATE = 11'sd512;

  // Reset values of the configuration registers.
  localparam logic [15:0] MAX_SPEED_RST = 16'd205;
  localparam logic [23:0] DIST_THR_RST = 24'd6554;
  localparam logic [14:0] ANG_THR_RST = 15'd3217;
  localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [1:0] CFG_DIST_THR = 2'd1;
  localparam logic [1:0] CFG_ANG_THR = 2'd2;

  // Request codes.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_POSE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DIFF,
    ST_SQ,
    ST_CMP,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_NORM,
    ST_ROT,
    ST_WRAP,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // Arctangent of 2^-i in rad*2^20.
  function automatic logic signed [ZW-1:0] atan_q20(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0: r = ZW'(823550);
      5'd1: r = ZW'(486170);
      5'd2: r = ZW'(256879);
      5'd3: r = ZW'(130396);
      5'd4: r = ZW'(65451);
      5'd5: r = ZW'(32757);
      5'd6: r = ZW'(16383);
      5'd7: r = ZW'(8192);
      5'd8: r = ZW'(4096);
      5'd9: r = ZW'(2048);
      5'd10: r = ZW'(1024);
      5'd11: r = ZW'(512);
      5'd12: r = ZW'(256);
      5'd13: r = ZW'(128);
      5'd14: r = ZW'(64);
      5'd15: r = ZW'(32);
      5'd16: r = ZW'(16);
      5'd17: r = ZW'(8);
      5'd18: r = ZW'(4);
      5'd19: r = ZW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/waypoint_drive_controller.sv @@
// Load and odometry words leave the block idle; a tick word yields one result word.
// A tick reads waypoints in the skip loop (one store read each), forms the quaternion
// products, makes two CORDIC runs of doublings and rotation steps, wraps the bearing,
// decides and loads the output register. One word is in work at a time; a finished
// result may wait while the next word is taken. rst_n is synchronous: it empties the
// path, zeroes position and speed, loads the unit quaternion, restores the registers.
`default_nettype none
module waypoint_drive_controller (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_req_type,
  input  wire logic                in_first_waypoint,
  input  wire logic signed [31:0]  in_pos_x,
  input  wire logic signed [31:0]  in_pos_y,
  input  wire logic signed [15:0]  in_quat_w,
  input  wire logic signed [15:0]  in_quat_x,
  input  wire logic signed [15:0]  in_quat_y,
  input  wire logic signed [15:0]  in_quat_z,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [15:0]              out_linear_speed,
  output logic signed [10:0]       out_angular_rate,
  output logic                     out_path_active,
  output logic                     out_goal_reached,
  output logic [5:0]               out_target_waypoint,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [23:0]         cfg_wdata
);

  localparam int AW = wdc_pkg::ADDR_W;
  localparam int LW = wdc_pkg::LEN_W;
  localparam int CW = wdc_pkg::CW;
  localparam int ZW = wdc_pkg::ZW;
  localparam int BW = wdc_pkg::BW;

  wdc_pkg::state_t state_r, state_nxt;

  logic [15:0] max_speed_r;
  logic [23:0] dist_thr_r;
  logic [14:0] ang_thr_r;
  logic [47:0] thr_sq_r;

  logic [LW-1:0] path_len_r;
  logic [AW-1:0] tgt_r;
  logic signed [31:0] robot_x_r, robot_y_r;
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic [15:0] speed_r;
  logic signed [10:0] turn_r;
  logic goal_r;

  logic [63:0] wp_mem [wdc_pkg::PATH_DEPTH];
  logic [63:0] rd_data_r;
  logic mem_we;
  logic [AW-1:0] mem_waddr;

  logic signed [32:0] dx_r, dy_r;
  logic far_r;
  logic [47:0] sqx_r, sqy_r;
  logic signed [31:0] prod_a_r, prod_b_r, num_r;

  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r, yaw_r;
  logic [wdc_pkg::STEP_W-1:0] step_r;
  logic phase_r;
  logic signed [BW-1:0] brg_r;

  logic out_valid_r;
  logic [15:0] out_speed_r;
  logic signed [10:0] out_turn_r;
  logic out_active_r, out_goal_r;
  logic [5:0] out_tgt_r;

  // Handshake strobes.
  logic accept, slot_free, out_load;
  assign accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Load addressing: a first waypoint restarts at entry zero.
  logic load_ok;
  assign load_ok = in_first_waypoint || (path_len_r < LW'(wdc_pkg::PATH_DEPTH));
  assign mem_waddr = in_first_waypoint ? '0 : path_len_r[AW-1:0];
  assign mem_we = accept && (in_req_type == wdc_pkg::REQ_LOAD) && load_ok;

  // Distance check arithmetic.
  logic signed [31:0] wp_x, wp_y;
  logic [32:0] magx, magy;
  logic [48:0] sq_sum;
  logic near, last_wp;
  logic [LW-1:0] tgt_inc;
  assign wp_x = rd_data_r[31:0];
  assign wp_y = rd_data_r[63:32];
  assign magx = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign magy = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign near = !far_r && (sq_sum < {1'b0, thr_sq_r});
  assign tgt_inc = LW'(tgt_r) + LW'(1);
  assign last_wp = tgt_inc >= path_len_r;

  // CORDIC step arithmetic.
  logic c_zero, c_small, rot_last, cordic_fin;
  logic signed [CW-1:0] xs, ys, cx_rot, cy_rot;
  logic signed [ZW-1:0] cz_rot, cz_fin;
  assign c_zero = (cx_r == '0) && (cy_r == '0);
  assign c_small = (cx_r < wdc_pkg::NORM_LIMIT) && (cx_r > -wdc_pkg::NORM_LIMIT) &&
                   (cy_r < wdc_pkg::NORM_LIMIT) && (cy_r > -wdc_pkg::NORM_LIMIT);
  assign xs = cx_r >>> step_r;
  assign ys = cy_r >>> step_r;
  assign cx_rot = cy_r[CW-1] ? cx_r - ys : cx_r + ys;
  assign cy_rot = cy_r[CW-1] ? cy_r + xs : cy_r - xs;
  assign cz_rot = cy_r[CW-1] ? cz_r - wdc_pkg::atan_q20(step_r)
                             : cz_r + wdc_pkg::atan_q20(step_r);
  assign rot_last = step_r == wdc_pkg::STEP_W'(wdc_pkg::CORDIC_STEPS - 1);
  assign cordic_fin = ((state_r == wdc_pkg::ST_NORM) && c_zero) ||
                      ((state_r == wdc_pkg::ST_ROT) && rot_last);
  assign cz_fin = (state_r == wdc_pkg::ST_NORM) ? '0 : cz_rot;

  // Quaternion yaw operands.
  logic signed [33:0] prod_sum, den;
  assign prod_sum = 34'(prod_a_r) + 34'(prod_b_r);
  assign den = (34'sd1 <<< 28) - (prod_sum <<< 1);

  // Bearing wrap and decision.
  logic brg_hi, brg_lo, drive;
  logic [BW-1:0] brg_mag;
  logic [16:0] speed_sum;
  assign brg_hi = brg_r > BW'(wdc_pkg::PI_Q20);
  assign brg_lo = brg_r <= -BW'(wdc_pkg::PI_Q20);
  assign brg_mag = brg_r[BW-1] ? BW'(-brg_r) : BW'(brg_r);
  assign drive = brg_mag < BW'({ang_thr_r, 7'b0});
  assign speed_sum = {1'b0, speed_r} + {1'b0, wdc_pkg::SPEED_STEP};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wdc_pkg::ST_IDLE: begin
        if (accept && (in_req_type == wdc_pkg::REQ_TICK)) begin
          state_nxt = (path_len_r != '0) ? wdc_pkg::ST_RD : wdc_pkg::ST_OUT;
        end
      end
      wdc_pkg::ST_RD: state_nxt = wdc_pkg::ST_DIFF;
      wdc_pkg::ST_DIFF: state_nxt = wdc_pkg::ST_SQ;
      wdc_pkg::ST_SQ: state_nxt = wdc_pkg::ST_CMP;
      wdc_pkg::ST_CMP: begin
        if (!near) begin
          state_nxt = wdc_pkg::ST_MUL1;
        end else begin
          state_nxt = last_wp ? wdc_pkg::ST_OUT : wdc_pkg::ST_RD;
        end
      end
      wdc_pkg::ST_MUL1: state_nxt = wdc_pkg::ST_MUL2;
      wdc_pkg::ST_MUL2: state_nxt = wdc_pkg::ST_MUL3;
      wdc_pkg::ST_MUL3: state_nxt = wdc_pkg::ST_NORM;
      wdc_pkg::ST_NORM: begin
        if (c_zero) begin
          state_nxt = phase_r ? wdc_pkg::ST_WRAP : wdc_pkg::ST_NORM;
        end else if (!c_small) begin
          state_nxt = wdc_pkg::ST_ROT;
        end
      end
      wdc_pkg::ST_ROT: begin
        if (rot_last) begin
          state_nxt = phase_r ? wdc_pkg::ST_WRAP : wdc_pkg::ST_NORM;
        end
      end
      wdc_pkg::ST_WRAP: begin
        if (!brg_hi && !brg_lo) begin
          state_nxt = wdc_pkg::ST_DECIDE;
        end
      end
      wdc_pkg::ST_DECIDE: state_nxt = wdc_pkg::ST_OUT;
      wdc_pkg::ST_OUT: begin
        if (slot_free) begin
          state_nxt = wdc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wdc_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = (state_r != wdc_pkg::ST_IDLE);
    out_load = (state_r == wdc_pkg::ST_OUT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wdc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Waypoint store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wp_mem[mem_waddr] <= {in_pos_y, in_pos_x};
    end
    if (state_r == wdc_pkg::ST_RD) begin
      rd_data_r <= wp_mem[tgt_r];
    end
  end

  // Configuration registers and the squared reach radius.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= wdc_pkg::MAX_SPEED_RST;
      dist_thr_r <= wdc_pkg::DIST_THR_RST;
      ang_thr_r <= wdc_pkg::ANG_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wdc_pkg::CFG_MAX_SPEED: max_speed_r <= cfg_wdata[15:0];
        wdc_pkg::CFG_DIST_THR: dist_thr_r <= cfg_wdata;
        wdc_pkg::CFG_ANG_THR: ang_thr_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= dist_thr_r * dist_thr_r;
  end

  // Path, pose and speed state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_len_r <= '0;
      tgt_r <= '0;
      robot_x_r <= '0;
      robot_y_r <= '0;
      qw_r <= wdc_pkg::QUAT_ONE;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
      speed_r <= '0;
    end else begin
      if (accept) begin
        unique case (in_req_type)
          wdc_pkg::REQ_LOAD: begin
            if (in_first_waypoint) begin
              path_len_r <= LW'(1);
              tgt_r <= '0;
            end else if (load_ok) begin
              path_len_r <= path_len_r + LW'(1);
            end
          end
          wdc_pkg::REQ_POSE: begin
            robot_x_r <= in_pos_x;
            robot_y_r <= in_pos_y;
            qw_r <= in_quat_w;
            qx_r <= in_quat_x;
            qy_r <= in_quat_y;
            qz_r <= in_quat_z;
          end
          wdc_pkg::REQ_TICK: begin
            if (path_len_r == '0) begin
              speed_r <= '0;
            end
          end
          default: ;
        endcase
      end
      if ((state_r == wdc_pkg::ST_CMP) && near) begin
        if (last_wp) begin
          path_len_r <= '0;
          tgt_r <= '0;
          speed_r <= '0;
        end else begin
          tgt_r <= tgt_r + AW'(1);
        end
      end
      if (state_r == wdc_pkg::ST_DECIDE) begin
        if (drive) begin
          speed_r <= (speed_sum > {1'b0, max_speed_r}) ? max_speed_r : speed_sum[15:0];
        end else begin
          speed_r <= '0;
        end
      end
    end
  end

  // Tick datapath: distance check, yaw products, shared CORDIC, bearing wrap, turn decision.
  always_ff @(posedge clk) begin
    unique case (state_r)
      wdc_pkg::ST_IDLE: begin
        goal_r <= 1'b0;
        turn_r <= '0;
      end
      wdc_pkg::ST_DIFF: begin
        dx_r <= 33'(wp_x) - 33'(robot_x_r);
        dy_r <= 33'(wp_y) - 33'(robot_y_r);
      end
      wdc_pkg::ST_SQ: begin
        far_r <= (magx[32:24] != '0) || (magy[32:24] != '0);
        sqx_r <= magx[23:0] * magx[23:0];
        sqy_r <= magy[23:0] * magy[23:0];
      end
      wdc_pkg::ST_CMP: begin
        if (near && last_wp) begin
          goal_r <= 1'b1;
        end
      end
      wdc_pkg::ST_MUL1: begin
        prod_a_r <= qw_r * qz_r;
        prod_b_r <= qx_r * qy_r;
      end
      wdc_pkg::ST_MUL2: begin
        num_r <= 32'(prod_sum <<< 1);
        prod_a_r <= qy_r * qy_r;
        prod_b_r <= qz_r * qz_r;
      end
      wdc_pkg::ST_MUL3: begin
        cx_r <= CW'(den);
        cy_r <= CW'(num_r);
        cz_r <= '0;
        phase_r <= 1'b0;
      end
      wdc_pkg::ST_NORM: begin
        step_r <= '0;
        if (!c_zero && c_small) begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end else if (!c_zero && cx_r[CW-1]) begin
          cz_r <= cy_r[CW-1] ? -wdc_pkg::PI_Q20 : wdc_pkg::PI_Q20;
          cx_r <= -cx_r;
          cy_r <= -cy_r;
        end
      end
      wdc_pkg::ST_ROT: begin
        // On the last step the run's end below takes over the vector.
        if (!rot_last) begin
          cx_r <= cx_rot;
          cy_r <= cy_rot;
          cz_r <= cz_rot;
        end
        step_r <= step_r + wdc_pkg::STEP_W'(1);
      end
      wdc_pkg::ST_WRAP: begin
        if (brg_hi) begin
          brg_r <= brg_r - wdc_pkg::TWO_PI_Q20;
        end else if (brg_lo) begin
          brg_r <= brg_r + wdc_pkg::TWO_PI_Q20;
        end
      end
      wdc_pkg::ST_DECIDE: begin
        if (drive) begin
          turn_r <= '0;
        end else begin
          turn_r <= brg_r[BW-1] ? -wdc_pkg::TURN_RATE : wdc_pkg::TURN_RATE;
        end
      end
      default: ;
    endcase
    // End of a CORDIC run: keep the yaw and start the target vector, or form the bearing.
    if (cordic_fin) begin
      if (!phase_r) begin
        yaw_r <= cz_fin;
        cx_r <= CW'(dx_r);
        cy_r <= CW'(dy_r);
        cz_r <= '0;
        phase_r <= 1'b1;
      end else begin
        brg_r <= BW'(cz_fin) - BW'(yaw_r);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_speed_r <= speed_r;
      out_turn_r <= turn_r;
      out_active_r <= (path_len_r != '0);
      out_goal_r <= goal_r;
      out_tgt_r <= 6'(tgt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_linear_speed = out_speed_r;
  assign out_angular_rate = out_turn_r;
  assign out_path_active = out_active_r;
  assign out_goal_reached = out_goal_r;
  assign out_target_waypoint = out_tgt_r;

  // Checks.
  `include "waypoint_drive_controller_assert.svh"
  `WDC_ASSERT_IMPL(a_len_bound, 1'b1, path_len_r <= LW'(wdc_pkg::PATH_DEPTH))
  `WDC_ASSERT_IMPL(a_tgt_in_path, path_len_r != '0, LW'(tgt_r) < path_len_r)
  `WDC_ASSERT_IMPL(a_drive_or_turn, out_valid && out_linear_speed != '0, out_angular_rate == '0)
  `WDC_ASSERT_IMPL(a_goal_ends_path, out_valid && out_goal_reached, !out_path_active)

endmodule
`default_nettype wire

@@ verif/tb_waypoint_drive_controller.sv @@
`timescale 1ns / 100ps
module tb_waypoint_drive_controller;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam longint PI_Q = 3294199;
  localparam longint TWO_PI_Q = 6588398;
  localparam longint NORM_LIM = 64'sd1 <<< 40;
  localparam longint ATAN_TBL [20] = '{823550, 486170, 256879, 130396, 65451, 32757,
    16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct {
    logic [15:0] speed;
    logic signed [10:0] rate;
    logic active;
    logic goal;
    logic [5:0] target;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = wdc_pkg::REQ_LOAD;
  logic in_first_waypoint = 1'b0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_linear_speed;
  logic signed [10:0] out_angular_rate;
  logic out_path_active, out_goal_reached;
  logic [5:0] out_target_waypoint;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = wdc_pkg::CFG_MAX_SPEED;
  logic [23:0] cfg_wdata = '0;

  waypoint_drive_controller dut (.*);

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the controller state.
  int signed route_x [wdc_pkg::PATH_DEPTH];
  int signed route_y [wdc_pkg::PATH_DEPTH];
  int unsigned route_len, aim_idx;
  int signed bot_x, bot_y, qw, qx, qy, qz;
  int unsigned speed_cmd, lim_speed, reach_radius, aim_tol;

  drive_cmd_t cmd_q[$];
  int mismatches = 0;
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_start = 1'b0;
  bit hold_on = 1'b0;

  // Vectoring CORDIC: angle of (x, y) in rad*2^20.
  function automatic longint vector_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while ((x < 0 ? -x : x) < NORM_LIM && (y < 0 ? -y : y) < NORM_LIM) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      z = (y >= 0) ? PI_Q : -PI_Q;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_TBL[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic bit waypoint_near(int unsigned k);
    longint dx, dy, thr;
    dx = longint'(route_x[k]) - bot_x;
    dy = longint'(route_y[k]) - bot_y;
    dx = dx < 0 ? -dx : dx;
    dy = dy < 0 ? -dy : dy;
    thr = reach_radius;
    if (dx >= (64'sd1 <<< 24) || dy >= (64'sd1 <<< 24)) return 1'b0;
    return (dx * dx + dy * dy) < thr * thr;
  endfunction

  // Advance the shadow state by one word; ticks queue their expected command.
  task automatic steer_update(logic [1:0] req, logic first, int signed px, int signed py,
                              int signed w, int signed x, int signed y, int signed z);
    drive_cmd_t c;
    bit goal;
    longint num, den, bearing;
    goal = 1'b0;
    c.rate = '0;
    if (req == wdc_pkg::REQ_LOAD) begin
      if (first) begin
        route_len = 0;
        aim_idx = 0;
      end
      if (route_len < wdc_pkg::PATH_DEPTH) begin
        route_x[route_len] = px;
        route_y[route_len] = py;
        route_len++;
      end
    end else if (req == wdc_pkg::REQ_POSE) begin
      bot_x = px; bot_y = py; qw = w; qx = x; qy = y; qz = z;
    end else if (req == wdc_pkg::REQ_TICK) begin
      if (route_len > 0) begin
        while (waypoint_near(aim_idx)) begin
          aim_idx++;
          if (aim_idx >= route_len) begin
            route_len = 0;
            aim_idx = 0;
            goal = 1'b1;
            break;
          end
        end
      end
      if (route_len > 0) begin
        num = 2 * (longint'(qw) * qz + longint'(qx) * qy);
        den = (64'sd1 <<< 28) - 2 * (longint'(qy) * qy + longint'(qz) * qz);
        bearing = vector_angle(longint'(route_x[aim_idx]) - bot_x,
                               longint'(route_y[aim_idx]) - bot_y) - vector_angle(den, num);
        while (bearing > PI_Q) bearing -= TWO_PI_Q;
        while (bearing <= -PI_Q) bearing += TWO_PI_Q;
        if ((bearing < 0 ? -bearing : bearing) < longint'(aim_tol) * 128) begin
          speed_cmd += wdc_pkg::SPEED_STEP;
          if (speed_cmd > lim_speed) speed_cmd = lim_speed;
        end else begin
          speed_cmd = 0;
          c.rate = (bearing < 0) ? -wdc_pkg::TURN_RATE : wdc_pkg::TURN_RATE;
        end
      end else begin
        speed_cmd = 0;
      end
      c.speed = speed_cmd[15:0];
      c.active = route_len > 0;
      c.goal = goal;
      c.target = aim_idx[5:0];
      cmd_q = {cmd_q, c};
    end
  endtask

  // Send one word and wait until it is accepted.
  task automatic send_word(logic [1:0] req, logic first, int signed px, int signed py,
                           int signed w = 16384, int signed x = 0, int signed y = 0,
                           int signed z = 0);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = req;
    in_first_waypoint = first;
    in_pos_x = px; in_pos_y = py;
    in_quat_w = 16'(w); in_quat_x = 16'(x); in_quat_y = 16'(y); in_quat_z = 16'(z);
    do @(posedge clk); while (in_stall);
    steer_update(req, first, px, py, w, x, y, z);
  endtask

  function automatic int signed rand_quat();
    return $signed($urandom_range(32768)) - 16384;
  endfunction

  // Wait until every expected result word has come out.
  task automatic wait_drained();
    while (cmd_q.size() != 0) @(posedge clk);
  endtask

  // Let the block drain, then write one register.
  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[23:0];
    case (idx)
      wdc_pkg::CFG_MAX_SPEED: lim_speed = value & 32'hFFFF;
      wdc_pkg::CFG_DIST_THR: reach_radius = value & 32'hFFFFFF;
      default: aim_tol = value & 32'h7FFF;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Long hold-off of the result side, counted in cycles.
  initial begin : hold_off
    @(posedge hold_start);
    hold_on = 1'b1;
    for (int n = 0; n < 400; n++) @(negedge clk);
    hold_on = 1'b0;
  end

  // Result side idles at random, or holds off for the counted stretch.
  always @(negedge clk) begin
    if (hold_on) begin
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 27);
    end
  end

  // Compare every accepted result word with the oldest expected command.
  always @(posedge clk) begin
    drive_cmd_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_q.size() == 0) begin
        errors++;
        $display("Unexpected result word at %0t", $time);
      end else begin
        e = cmd_q.pop_front();
        if (out_linear_speed !== e.speed || out_angular_rate !== e.rate ||
            out_path_active !== e.active || out_goal_reached !== e.goal ||
            out_target_waypoint !== e.target) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected %0d %0d %0b %0b %0d, got %0d %0d %0b %0b %0d",
                     $time, e.speed, e.rate, e.active, e.goal, e.target, out_linear_speed,
                     out_angular_rate, out_path_active, out_goal_reached,
                     out_target_waypoint);
        end
      end
    end
  end

  // Ticks with no path and the unused request code, then a plain load and a tick on it.
  task automatic test_no_path();
    send_word(wdc_pkg::REQ_TICK, 1'b0, 0, 0);
    send_word(REQ_NONE, 1'b1, 32'sh7FFFFFFF, -32'sh80000000, -16384, 16384, -1, 1);
    send_word(wdc_pkg::REQ_LOAD, 1'b0, 65536, 0);
    send_word(wdc_pkg::REQ_TICK, 1'b0, 0, 0);
  endtask

  // Field extremes, zero vector and zero bearing outside the tolerance.
  task automatic test_extremes();
    write_reg(wdc_pkg::CFG_DIST_THR, 0);
    write_reg(wdc_pkg::CFG_ANG_THR, 0);
    send_word(wdc_pkg::REQ_LOAD, 1'b1, 0, 0);
    send_word(wdc_pkg::REQ_TICK, 1'b0, 0, 0);
    write_reg(wdc_pkg::CFG_ANG_THR, 25736);
    send_word(wdc_pkg::REQ_LOAD, 1'b1, 32'sh7FFFFFFF, -32'sh80000000);
    send_word(wdc_pkg::REQ_POSE, 1'b0, -32'sh80000000, 32'sh7FFFFFFF,
              -16384, -16384, 16384, 16384);
    send_word(wdc_pkg::REQ_TICK, 1'b0, 0, 0);
    send_word(wdc_pkg::REQ_POSE, 1'b0, 32'sh7FFFFFFF, -32'sh80000000, 16384, 0, 0, -16384);
    send_word(wdc_pkg::REQ_TICK, 1'b0, 0, 0);
    send_word(wdc_pkg::REQ_POSE, 1'b0, -1, -1, 0, 16384, -16384, 0);
    send_word(wdc_pkg::REQ_TICK, 1'b0, 0, 0);
  endtask

  // Overfill the store, then walk the whole path to the goal.
  task automatic test_store_full();
    write_reg(wdc_pkg::CFG_DIST_THR, 16777215);
    send_word(wdc_pkg::REQ_LOAD, 1'b1, 0, 0);
    for (int k = 1; k < wdc_pkg::PATH_DEPTH + 3; k++)
      send_word(wdc_pkg::REQ_LOAD, 1'b0, k * 4096, 0);
    send_word(wdc_pkg::REQ_POSE, 1'b0, 0, 0);
    send_word(wdc_pkg::REQ_TICK, 1'b0, 0, 0);
    send_word(wdc_pkg::REQ_TICK, 1'b0, 0, 0);
  endtask

  // Well-formed routes: load a path, then drive along it with noisy poses.
  task automatic drive_routes(int words);
    int base_x, base_y, len, spread, start;
    start = 0;
    while (start < words) begin
      len = $urandom_range(9, 1);
      spread = 1 << $urandom_range(17, 10);
      base_x = $urandom;
      base_y = $urandom;
      base_x = base_x >>> $urandom_range(12, 2);
      base_y = base_y >>> $urandom_range(12, 2);
      for (int k = 0; k < len; k++) begin
        send_word(wdc_pkg::REQ_LOAD, k == 0 || $urandom_range(19) == 0,
                  base_x + k * spread, base_y + $signed($urandom_range(2 * spread)) - spread);
        start++;
      end
      for (int k = 0; k < 3 * len + 2; k++) begin
        if ($urandom_range(9) == 0) begin
          send_word(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom, $urandom,
                    rand_quat(), rand_quat(), rand_quat(), rand_quat());
        end else begin
          send_word(wdc_pkg::REQ_POSE, 1'b0,
                    route_x[aim_idx % wdc_pkg::PATH_DEPTH] + $signed($urandom_range(8192)) - 4096
                      - (($urandom_range(2) == 0) ? spread : 0),
                    route_y[aim_idx % wdc_pkg::PATH_DEPTH] + $signed($urandom_range(8192)) - 4096,
                    rand_quat(), rand_quat(), rand_quat(), rand_quat());
        end
        send_word(wdc_pkg::REQ_TICK, 1'($urandom_range(1)), $urandom, $urandom);
        start += 2;
      end
    end
  endtask

  // Hold the result side off while words keep coming.
  task automatic test_backpressure();
    hold_start = 1'b1;
    drive_routes(40);
  endtask

  // Several register settings, extremes included, with routes under each.
  task automatic test_config_sweep();
    write_reg(wdc_pkg::CFG_MAX_SPEED, 65535);
    write_reg(wdc_pkg::CFG_DIST_THR, 6554);
    write_reg(wdc_pkg::CFG_ANG_THR, 3217);
    drive_routes(300);
    quiet = 1'b1;
    drive_routes(150);
    quiet = 1'b0;
    write_reg(wdc_pkg::CFG_MAX_SPEED, 0);
    write_reg(wdc_pkg::CFG_DIST_THR, 30000);
    write_reg(wdc_pkg::CFG_ANG_THR, 25736);
    drive_routes(300);
    write_reg(wdc_pkg::CFG_MAX_SPEED, 500);
    write_reg(wdc_pkg::CFG_DIST_THR, 0);
    write_reg(wdc_pkg::CFG_ANG_THR, 0);
    drive_routes(200);
    write_reg(wdc_pkg::CFG_MAX_SPEED, $urandom_range(65535));
    write_reg(wdc_pkg::CFG_DIST_THR, $urandom_range(200000));
    write_reg(wdc_pkg::CFG_ANG_THR, $urandom_range(25736));
    drive_routes(300);
    write_reg(wdc_pkg::CFG_MAX_SPEED, 205);
    write_reg(wdc_pkg::CFG_DIST_THR, 16777215);
    write_reg(wdc_pkg::CFG_ANG_THR, 12000);
    drive_routes(150);
  endtask

  // Main sequence.
  initial begin
    route_len = 0; aim_idx = 0; bot_x = 0; bot_y = 0;
    qw = 16384; qx = 0; qy = 0; qz = 0; speed_cmd = 0;
    lim_speed = 205; reach_radius = 6554; aim_tol = 3217;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_no_path();
    test_extremes();
    test_store_full();
    test_backpressure();
    test_config_sweep();
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (500) @(posedge clk);
    if (errors == 0 && mismatches == 0 && cmd_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Run limit.
  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
